[hw/rtl/ttbi_pkg.sv]
package ttbi_pkg;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic [1:0] REG_SUN_INTERVALS     = 2'd0;
  localparam logic [1:0] REG_EARTH_INTERVALS   = 2'd1;
  localparam logic [1:0] REG_AZIMUTH_INTERVALS = 2'd2;
  localparam logic [1:0] REG_BLUE_FRACTION     = 2'd3;

  typedef struct packed {
    logic       write;
    logic       capture;
    logic       read;
    logic [3:0] corner;
    logic       load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic bad;
    logic done;
  } ctrl_stat_t;

endpackage

[hw/rtl/trilinear_table_blend_interpolator.sv]
// Load beat: written into the grid memory at the accepting edge, no result; the next beat
// can be taken on the following edge. Query beat: the result beat comes after 16 corner
// reads from the single grid memory port, 4 lerp levels, a done handoff and an output
// load, which waits while a held result is stalled; one query at a time. A cosine out of
// range skips the corner reads and goes straight to the output load.
// Reset (synchronous, rst high): controller idle, no result pending, registers at
// 15/15/15/0; grid contents are not cleared and read as undefined until loaded.
module trilinear_table_blend_interpolator #(
  parameter int AXIS_POINTS = 16
) (
  input  logic               clk,
  input  logic               rst,
  // item channel
  input  logic               item_valid,
  output logic               item_stall,
  input  logic               operation,
  input  logic               grid_select,
  input  logic [3:0]         sun_slot,
  input  logic [3:0]         earth_slot,
  input  logic [3:0]         azimuth_slot,
  input  logic [23:0]        entry_value,
  input  logic signed [17:0] cos_sun,
  input  logic signed [17:0] cos_earth,
  input  logic signed [17:0] cos_azimuth,
  // result channel
  output logic               result_valid,
  input  logic               result_stall,
  output logic [23:0]        factor,
  output logic               out_of_range,
  // configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  logic [3:0]  sun_intervals;
  logic [3:0]  earth_intervals;
  logic [3:0]  azimuth_intervals;
  logic [16:0] blue_fraction;
  logic        cfg_write;

  ttbi_pkg::ctrl_cmd_t  cmd;
  ttbi_pkg::ctrl_stat_t stat;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  // Register file: only to be written while no query is in flight (user's duty, unenforced).
  always_ff @(posedge clk) begin
    if (rst) begin
      sun_intervals     <= 4'd15;
      earth_intervals   <= 4'd15;
      azimuth_intervals <= 4'd15;
      blue_fraction     <= 17'd0;
    end else if (cfg_write) begin
      case (paddr[3:2])
        ttbi_pkg::REG_SUN_INTERVALS:     sun_intervals     <= pwdata[3:0];
        ttbi_pkg::REG_EARTH_INTERVALS:   earth_intervals   <= pwdata[3:0];
        ttbi_pkg::REG_AZIMUTH_INTERVALS: azimuth_intervals <= pwdata[3:0];
        ttbi_pkg::REG_BLUE_FRACTION:     blue_fraction     <= pwdata[16:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      ttbi_pkg::REG_SUN_INTERVALS:     prdata = 32'(sun_intervals);
      ttbi_pkg::REG_EARTH_INTERVALS:   prdata = 32'(earth_intervals);
      ttbi_pkg::REG_AZIMUTH_INTERVALS: prdata = 32'(azimuth_intervals);
      ttbi_pkg::REG_BLUE_FRACTION:     prdata = 32'(blue_fraction);
      default:                         prdata = 32'd0;
    endcase
  end

  // Sequencer: accepts a beat, walks 16 corners for an in-range query, loads the output.
  ttbi_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_stall(item_stall), .operation(operation),
    .result_valid(result_valid), .result_stall(result_stall),
    .cmd(cmd), .stat(stat)
  );

  // Grid memory, axis location and the lerp ladder.
  ttbi_datapath #(.AXIS_POINTS(AXIS_POINTS)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .stat(stat),
    .grid_select(grid_select), .sun_slot(sun_slot), .earth_slot(earth_slot),
    .azimuth_slot(azimuth_slot), .entry_value(entry_value),
    .cos_sun(cos_sun), .cos_earth(cos_earth), .cos_azimuth(cos_azimuth),
    .sun_intervals(sun_intervals), .earth_intervals(earth_intervals),
    .azimuth_intervals(azimuth_intervals), .blue_fraction(blue_fraction),
    .factor(factor), .out_of_range(out_of_range)
  );

endmodule

[hw/rtl/ttbi_locate.sv]
module ttbi_locate (
  input  logic signed [17:0] cosine,
  input  logic [3:0]         intervals,
  input  logic               span_wide,
  output logic [3:0]         lo,
  output logic [3:0]         hi,
  output logic [15:0]        frac,
  output logic               bad
);

  logic signed [18:0] offset;
  logic [17:0]        span;
  logic [17:0]        excess;
  logic [21:0]        excess_n;
  logic [21:0]        limit;
  logic               below;
  logic               above;
  logic [17:0]        clamped;
  logic [21:0]        pos;
  logic [3:0]         n;
  logic [4:0]         lo_plus;

  always_comb begin
    n      = (intervals == 4'd0) ? 4'd1 : intervals;
    offset = span_wide ? ({cosine[17], cosine} + 19'sd65536) : {cosine[17], cosine};
    span   = span_wide ? 18'd131072 : 18'd65536;
    // floor(span / 1000): excess * n * 1000 > span  <=>  excess * n > limit
    limit  = span_wide ? 22'd131 : 22'd65;
    below  = offset < 19'sd0;
    above  = !below && (offset[17:0] > span);
    if (below) begin
      excess = 18'(-offset);
    end else if (above) begin
      excess = offset[17:0] - span;
    end else begin
      excess = 18'd0;
    end
    excess_n = 22'(excess) * 22'(n);
    bad      = excess_n > limit;
    clamped  = below ? 18'd0 : (above ? span : offset[17:0]);
    pos      = 22'(clamped) * 22'(n);
    if (span_wide) begin
      lo   = pos[20:17];
      frac = pos[16:1];
    end else begin
      lo   = pos[19:16];
      frac = pos[15:0];
    end
    lo_plus = 5'(lo) + 5'd1;
    hi      = (lo_plus > 5'(n)) ? lo : lo_plus[3:0];
  end

endmodule

[hw/rtl/ttbi_datapath.sv]
module ttbi_datapath #(
  parameter int AXIS_POINTS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  ttbi_pkg::ctrl_cmd_t cmd,
  output ttbi_pkg::ctrl_stat_t stat,
  input  logic                grid_select,
  input  logic [3:0]          sun_slot,
  input  logic [3:0]          earth_slot,
  input  logic [3:0]          azimuth_slot,
  input  logic [23:0]         entry_value,
  input  logic signed [17:0]  cos_sun,
  input  logic signed [17:0]  cos_earth,
  input  logic signed [17:0]  cos_azimuth,
  input  logic [3:0]          sun_intervals,
  input  logic [3:0]          earth_intervals,
  input  logic [3:0]          azimuth_intervals,
  input  logic [16:0]         blue_fraction,
  output logic [23:0]         factor,
  output logic                out_of_range
);

  localparam int GRID  = AXIS_POINTS * AXIS_POINTS * AXIS_POINTS;
  localparam int DEPTH = 2 * GRID;
  localparam int AW    = $clog2(DEPTH);
  localparam int IB    = $clog2(AXIS_POINTS);

  function automatic logic [23:0] lerp(input logic [23:0] a, input logic [23:0] b,
                                       input logic [16:0] r);
    logic signed [24:0] diff;
    logic signed [42:0] prod;
    logic signed [42:0] shifted;
    diff    = $signed({1'b0, b}) - $signed({1'b0, a});
    prod    = 43'(diff) * 43'($signed({1'b0, r}));
    shifted = (prod + 43'sd32768) >>> 16;
    return 24'(43'(a) + shifted);
  endfunction

  function automatic logic [IB-1:0] cap(input logic [3:0] i);
    if (32'(i) > AXIS_POINTS - 1) begin
      return IB'(AXIS_POINTS - 1);
    end else begin
      return IB'(i);
    end
  endfunction

  function automatic logic [AW-1:0] addr_of(input logic g, input logic [IB-1:0] s,
                                            input logic [IB-1:0] e, input logic [IB-1:0] z);
    return AW'(g) * AW'(GRID) + (AW'(s) * AW'(AXIS_POINTS) + AW'(e)) * AW'(AXIS_POINTS)
           + AW'(z);
  endfunction

  logic [23:0] mem [DEPTH];

  logic [3:0]  s_lo_w, s_hi_w, e_lo_w, e_hi_w, z_lo_w, z_hi_w;
  logic [15:0] s_fr_w, e_fr_w, z_fr_w;
  logic        s_bad_w, e_bad_w, z_bad_w;

  ttbi_locate u_loc_sun (
    .cosine(cos_sun), .intervals(sun_intervals), .span_wide(1'b0),
    .lo(s_lo_w), .hi(s_hi_w), .frac(s_fr_w), .bad(s_bad_w)
  );
  ttbi_locate u_loc_earth (
    .cosine(cos_earth), .intervals(earth_intervals), .span_wide(1'b0),
    .lo(e_lo_w), .hi(e_hi_w), .frac(e_fr_w), .bad(e_bad_w)
  );
  ttbi_locate u_loc_azimuth (
    .cosine(cos_azimuth), .intervals(azimuth_intervals), .span_wide(1'b1),
    .lo(z_lo_w), .hi(z_hi_w), .frac(z_fr_w), .bad(z_bad_w)
  );

  logic [IB-1:0] s_lo, s_hi, e_lo, e_hi, z_lo, z_hi;
  logic [16:0]   s_fr, e_fr, z_fr, weight;
  logic          bad;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      s_lo   <= cap(s_lo_w);
      s_hi   <= cap(s_hi_w);
      e_lo   <= cap(e_lo_w);
      e_hi   <= cap(e_hi_w);
      z_lo   <= cap(z_lo_w);
      z_hi   <= cap(z_hi_w);
      s_fr   <= {1'b0, s_fr_w};
      e_fr   <= {1'b0, e_fr_w};
      z_fr   <= {1'b0, z_fr_w};
      bad    <= s_bad_w || e_bad_w || z_bad_w;
      weight <= (blue_fraction > 17'd65536) ? 17'd65536 : blue_fraction;
    end
  end

  logic          slots_ok;
  logic [AW-1:0] waddr;
  logic [AW-1:0] raddr;

  always_comb begin
    slots_ok = (32'(sun_slot) < AXIS_POINTS) && (32'(earth_slot) < AXIS_POINTS)
               && (32'(azimuth_slot) < AXIS_POINTS);
    waddr = addr_of(grid_select, IB'(sun_slot), IB'(earth_slot), IB'(azimuth_slot));
    raddr = addr_of(cmd.corner[3],
                    cmd.corner[2] ? s_hi : s_lo,
                    cmd.corner[1] ? e_hi : e_lo,
                    cmd.corner[0] ? z_hi : z_lo);
  end

  logic [23:0] rdata;

  always_ff @(posedge clk) begin
    if (cmd.write && slots_ok) begin
      mem[waddr] <= entry_value;
    end
    if (cmd.read) begin
      rdata <= mem[raddr];
    end
  end

  // lerp ladder: azimuth, earth, sun, then blend across grids
  logic        rd_valid, l1_valid, l2_valid, l3_valid, fin_valid;
  logic [3:0]  rd_tag;
  logic [2:0]  l1_tag;
  logic [1:0]  l2_tag;
  logic        l3_tag;
  logic [23:0] z0, l1, e0, l2, s0, l3, g0, fin;

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid  <= 1'b0;
      l1_valid  <= 1'b0;
      l2_valid  <= 1'b0;
      l3_valid  <= 1'b0;
      fin_valid <= 1'b0;
    end else begin
      rd_valid  <= cmd.read;
      l1_valid  <= rd_valid && rd_tag[0];
      l2_valid  <= l1_valid && l1_tag[0];
      l3_valid  <= l2_valid && l2_tag[0];
      fin_valid <= l3_valid && l3_tag;
    end
  end

  always_ff @(posedge clk) begin
    rd_tag <= cmd.corner;
    if (rd_valid) begin
      if (rd_tag[0]) begin
        l1     <= lerp(z0, rdata, z_fr);
        l1_tag <= rd_tag[3:1];
      end else begin
        z0 <= rdata;
      end
    end
    if (l1_valid) begin
      if (l1_tag[0]) begin
        l2     <= lerp(e0, l1, e_fr);
        l2_tag <= l1_tag[2:1];
      end else begin
        e0 <= l1;
      end
    end
    if (l2_valid) begin
      if (l2_tag[0]) begin
        l3     <= lerp(s0, l2, s_fr);
        l3_tag <= l2_tag[1];
      end else begin
        s0 <= l2;
      end
    end
    if (l3_valid) begin
      if (l3_tag) begin
        fin <= lerp(g0, l3, weight);
      end else begin
        g0 <= l3;
      end
    end
    if (cmd.load_out) begin
      factor       <= bad ? 24'd0 : fin;
      out_of_range <= bad;
    end
  end

  assign stat.bad  = bad;
  assign stat.done = fin_valid;

endmodule

[hw/rtl/ttbi_ctrl.sv]
module ttbi_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 item_valid,
  output logic                 item_stall,
  input  logic                 operation,
  output logic                 result_valid,
  input  logic                 result_stall,
  output ttbi_pkg::ctrl_cmd_t  cmd,
  input  ttbi_pkg::ctrl_stat_t stat
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_READ = 2'd1;
  localparam logic [1:0] ST_WAIT = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  logic [1:0] state, state_next;
  logic [3:0] corner, corner_next;
  logic       accept;
  logic       out_free;

  always_comb begin
    item_stall   = (state != ST_IDLE);
    accept       = item_valid && !item_stall;
    out_free     = !result_valid || !result_stall;
    state_next   = state;
    corner_next  = corner;
    cmd.write    = accept && (operation == ttbi_pkg::OP_LOAD);
    cmd.capture  = accept && (operation == ttbi_pkg::OP_QUERY);
    cmd.read     = 1'b0;
    cmd.corner   = corner;
    cmd.load_out = 1'b0;
    case (state)
      ST_IDLE: begin
        corner_next = 4'd0;
        if (cmd.capture) begin
          state_next = ST_READ;
        end
      end
      ST_READ: begin
        if (stat.bad) begin
          state_next = ST_DONE;
        end else begin
          cmd.read    = 1'b1;
          corner_next = corner + 4'd1;
          if (corner == 4'd15) begin
            state_next = ST_WAIT;
          end
        end
      end
      ST_WAIT: begin
        if (stat.done) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      corner       <= 4'd0;
      result_valid <= 1'b0;
    end else begin
      state  <= state_next;
      corner <= corner_next;
      if (cmd.load_out) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

endmodule

[tb/sv/tb_trilinear_table_blend_interpolator.sv]
module tb_trilinear_table_blend_interpolator;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int AXIS_POINTS = 16;
  localparam int GRID_POINTS = AXIS_POINTS * AXIS_POINTS * AXIS_POINTS;
  localparam int Q16_ONE = 65536;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic item_valid = 1'b0;
  logic item_stall;
  logic operation = ttbi_pkg::OP_LOAD;
  logic grid_select = 1'b0;
  logic [3:0] sun_slot = '0;
  logic [3:0] earth_slot = '0;
  logic [3:0] azimuth_slot = '0;
  logic [23:0] entry_value = '0;
  logic signed [17:0] cos_sun = '0;
  logic signed [17:0] cos_earth = '0;
  logic signed [17:0] cos_azimuth = '0;

  logic result_valid;
  logic result_stall = 1'b0;
  logic [23:0] factor;
  logic out_of_range;

  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [3:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  typedef struct packed {
    logic [23:0] factor;
    logic        out_of_range;
  } blend_result_t;

  typedef struct {
    int unsigned lo;
    int unsigned hi;
    int unsigned frac;
    bit          bad;
  } axis_cell_t;

  // Shadow of the block: grid contents, which entries were loaded, registers.
  logic [23:0] grid_shadow [2*GRID_POINTS];
  bit          grid_loaded [2*GRID_POINTS];
  int unsigned sun_steps, earth_steps, azimuth_steps, blue_weight;

  blend_result_t pending_factors[$];
  int errors = 0;
  int results_seen = 0;
  int queries_sent = 0;
  int loads_sent = 0;

  // Idle percentages of each side, and the long receiver hold-off.
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_cycles = 0;

  trilinear_table_blend_interpolator #(.AXIS_POINTS(AXIS_POINTS)) u_dut (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin
    #50_000_000;
    $display("Regression FAIL");
    $finish;
  end

  // ---------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------
  function automatic axis_cell_t place_on_axis(longint c, longint first, longint width,
                                               int unsigned n);
    axis_cell_t a;
    longint last, p;
    if (n == 0) n = 1;
    last = first + width;
    a.bad = 1'b0;
    if (c < first) begin
      if ((first - c) * n * 1000 > width) a.bad = 1'b1;
      c = first;
    end
    if (c > last) begin
      if ((c - last) * n * 1000 > width) a.bad = 1'b1;
      c = last;
    end
    p = (c - first) * n;
    a.lo = int'(p / width);
    a.frac = int'(((p % width) * Q16_ONE) / width);
    a.hi = (a.lo + 1 > n) ? a.lo : a.lo + 1;
    if (a.lo > AXIS_POINTS - 1) a.lo = AXIS_POINTS - 1;
    if (a.hi > AXIS_POINTS - 1) a.hi = AXIS_POINTS - 1;
    return a;
  endfunction

  function automatic logic [23:0] mix(logic [23:0] a, logic [23:0] b, int unsigned r);
    longint unsigned s;
    s = longint'(a) * (Q16_ONE - r) + longint'(b) * r + 32768;
    return s[39:16];
  endfunction

  function automatic int unsigned grid_addr(int unsigned g, int unsigned s, int unsigned e,
                                            int unsigned z);
    return g * GRID_POINTS + (s * AXIS_POINTS + e) * AXIS_POINTS + z;
  endfunction

  function automatic logic [23:0] trilinear(int unsigned g, axis_cell_t s, axis_cell_t e,
                                            axis_cell_t z);
    logic [23:0] plane [2];
    logic [23:0] el, eh;
    int unsigned si;
    for (int k = 0; k < 2; k++) begin
      si = k ? s.hi : s.lo;
      el = mix(grid_shadow[grid_addr(g, si, e.lo, z.lo)],
               grid_shadow[grid_addr(g, si, e.lo, z.hi)], z.frac);
      eh = mix(grid_shadow[grid_addr(g, si, e.hi, z.lo)],
               grid_shadow[grid_addr(g, si, e.hi, z.hi)], z.frac);
      plane[k] = mix(el, eh, e.frac);
    end
    return mix(plane[0], plane[1], s.frac);
  endfunction

  task automatic predict_factor(logic signed [17:0] cs, logic signed [17:0] ce,
                                logic signed [17:0] cz);
    axis_cell_t s, e, z;
    blend_result_t r;
    int unsigned w;
    s = place_on_axis(cs, 0, Q16_ONE, sun_steps);
    e = place_on_axis(ce, 0, Q16_ONE, earth_steps);
    z = place_on_axis(cz, -Q16_ONE, 2 * Q16_ONE, azimuth_steps);
    if (s.bad || e.bad || z.bad) begin
      r.factor = '0;
      r.out_of_range = 1'b1;
    end else begin
      w = blue_weight > Q16_ONE ? Q16_ONE : blue_weight;
      r.factor = mix(trilinear(0, s, e, z), trilinear(1, s, e, z), w);
      r.out_of_range = 1'b0;
    end
    pending_factors.push_back(r);
  endtask

  // ---------------------------------------------------------------------
  // Beat drivers
  // ---------------------------------------------------------------------
  // Offer one beat, after random idle gaps set by send_idle_pct, and hold it until accepted;
  // with no gap, the caller's next beat follows on the next edge without dropping valid.
  task automatic send_beat(logic op, logic g, logic [3:0] s, logic [3:0] e, logic [3:0] z,
                           logic [23:0] v, logic signed [17:0] cs, logic signed [17:0] ce,
                           logic signed [17:0] cz);
    int idle;
    idle = 0;
    while ($urandom_range(99) < send_idle_pct && idle < 8) begin
      item_valid <= 1'b0;
      @(posedge clk);
      idle++;
    end
    item_valid <= 1'b1;
    operation <= op;
    grid_select <= g;
    sun_slot <= s;
    earth_slot <= e;
    azimuth_slot <= z;
    entry_value <= v;
    cos_sun <= cs;
    cos_earth <= ce;
    cos_azimuth <= cz;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    // Accepted at this edge: update the shadow in beat order.
    if (op == ttbi_pkg::OP_LOAD) begin
      loads_sent++;
      if (s < AXIS_POINTS && e < AXIS_POINTS && z < AXIS_POINTS) begin
        grid_shadow[grid_addr(g, s, e, z)] = v;
        grid_loaded[grid_addr(g, s, e, z)] = 1'b1;
      end
    end else begin
      queries_sent++;
      predict_factor(cs, ce, cz);
    end
  endtask

  task automatic release_channel();
    item_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic load_entry(logic g, logic [3:0] s, logic [3:0] e, logic [3:0] z,
                            logic [23:0] v);
    send_beat(ttbi_pkg::OP_LOAD, g, s, e, z, v, '0, '0, '0);
  endtask

  // Load every corner a query would read that has not been written yet.
  task automatic load_missing_corners(logic signed [17:0] cs, logic signed [17:0] ce,
                                      logic signed [17:0] cz);
    axis_cell_t s, e, z;
    int unsigned si, ei, zi, v;
    s = place_on_axis(cs, 0, Q16_ONE, sun_steps);
    e = place_on_axis(ce, 0, Q16_ONE, earth_steps);
    z = place_on_axis(cz, -Q16_ONE, 2 * Q16_ONE, azimuth_steps);
    if (s.bad || e.bad || z.bad) return;
    for (int g = 0; g < 2; g++) begin
      for (int k = 0; k < 8; k++) begin
        si = k[2] ? s.hi : s.lo;
        ei = k[1] ? e.hi : e.lo;
        zi = k[0] ? z.hi : z.lo;
        if (!grid_loaded[grid_addr(g, si, ei, zi)]) begin
          v = $urandom;
          load_entry(1'(g), 4'(si), 4'(ei), 4'(zi), v[23:0]);
        end
      end
    end
  endtask

  task automatic query(logic signed [17:0] cs, logic signed [17:0] ce,
                       logic signed [17:0] cz);
    load_missing_corners(cs, ce, cz);
    send_beat(ttbi_pkg::OP_QUERY, $urandom_range(1), $urandom_range(15), $urandom_range(15),
              $urandom_range(15), $urandom, cs, ce, cz);
  endtask

  // APB write: setup then access; pready is always high.
  task automatic write_register(logic [1:0] idx, logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      ttbi_pkg::REG_SUN_INTERVALS:     sun_steps = value[3:0];
      ttbi_pkg::REG_EARTH_INTERVALS:   earth_steps = value[3:0];
      ttbi_pkg::REG_AZIMUTH_INTERVALS: azimuth_steps = value[3:0];
      ttbi_pkg::REG_BLUE_FRACTION:     blue_weight = value[16:0];
      default: ;
    endcase
  endtask

  // Drain all results, then let any in-flight work settle.
  task automatic wait_idle();
    int guard;
    guard = 0;
    item_valid <= 1'b0;
    while (pending_factors.size() != 0 && guard < 200_000) begin
      @(posedge clk);
      guard++;
    end
    repeat (40) @(posedge clk);
  endtask

  task automatic configure(int unsigned s, int unsigned e, int unsigned z, int unsigned b);
    wait_idle();
    write_register(ttbi_pkg::REG_SUN_INTERVALS, s);
    write_register(ttbi_pkg::REG_EARTH_INTERVALS, e);
    write_register(ttbi_pkg::REG_AZIMUTH_INTERVALS, z);
    write_register(ttbi_pkg::REG_BLUE_FRACTION, b);
    @(posedge clk);
  endtask

  // ---------------------------------------------------------------------
  // Result side: stall at random, hold off on request, check each beat.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      if (result_valid && !result_stall) begin
        blend_result_t want;
        results_seen++;
        if (pending_factors.size() == 0) begin
          $error("result beat with nothing expected: factor %0h oor %0b",
                 factor, out_of_range);
          errors++;
        end else begin
          want = pending_factors.pop_front();
          if (factor !== want.factor) begin
            $error("factor: expected %0h, got %0h", want.factor, factor);
            errors++;
          end
          if (out_of_range !== want.out_of_range) begin
            $error("out_of_range: expected %0b, got %0b", want.out_of_range, out_of_range);
            errors++;
          end
        end
      end
      // Long hold-off wins over random stalling.
      if (hold_cycles > 0) begin
        hold_cycles <= hold_cycles - 1;
        result_stall <= 1'b1;
      end else begin
        result_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------
  function automatic logic signed [17:0] random_cosine(bit wide);
    int pick;
    pick = $urandom_range(99);
    if (pick < 70) return wide ? 18'($urandom_range(131072) - 65536) : 18'($urandom_range(65536));
    if (pick < 85) return wide ? 18'(-65536 - int'($urandom_range(6))) :
                                 18'(-int'($urandom_range(6)));
    if (pick < 95) return 18'(65536 + $urandom_range(6));
    return 18'($urandom);
  endfunction

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------
  task automatic test_directed_extremes();
    // Loads to a few corners, then queries at span edges, tolerance and beyond.
    load_entry(1'b0, 4'd0, 4'd0, 4'd0, 24'h000000);
    load_entry(1'b1, 4'd0, 4'd0, 4'd0, 24'hFFFFFF);
    load_entry(1'b0, 4'd15, 4'd15, 4'd15, 24'hFFFFFF);
    load_entry(1'b1, 4'd15, 4'd15, 4'd15, 24'h000001);
    load_entry(1'b0, 4'd8, 4'd8, 4'd8, 24'h123456);
    query(18'sd0, 18'sd0, -18'sd65536);
    query(18'sd65536, 18'sd65536, 18'sd65536);
    query(-18'sd4, 18'sd0, 18'sd0);          // inside clamp tolerance
    query(-18'sd5, 18'sd0, 18'sd0);          // just past tolerance
    query(18'sd0, 18'sd65540, 18'sd0);
    query(18'sd0, 18'sd0, -18'sd65545);
    query(18'sd32768, 18'sd21845, 18'sd1);
    query(18'sh1FFFF, 18'sh20000, 18'sd0);   // field extremes
    query(18'sh20000, 18'sh1FFFF, 18'sh3FFFF);
    release_channel();
  endtask

  task automatic test_register_settings();
    // Zero interval counts act as one; blend weight above one saturates.
    int unsigned cases [5][4] = '{'{0, 0, 0, 65536}, '{1, 1, 1, 131071},
                                  '{15, 15, 15, 0}, '{3, 7, 11, 32768},
                                  '{15, 1, 8, 65537}};
    foreach (cases[i]) begin
      configure(cases[i][0], cases[i][1], cases[i][2], cases[i][3]);
      query(18'sd0, 18'sd0, -18'sd65536);
      query(18'sd65536, 18'sd65536, 18'sd65536);
      query(18'($urandom_range(65536)), 18'($urandom_range(65536)),
            18'($urandom_range(131072) - 65536));
      release_channel();
    end
  endtask

  task automatic test_random_mix(int n);
    int unsigned v;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < 25) begin
        // Overwrite a grid entry anywhere in either grid.
        v = $urandom;
        load_entry($urandom_range(1), $urandom_range(15), $urandom_range(15),
                   $urandom_range(15), v[23:0]);
      end else begin
        query(random_cosine(0), random_cosine(0), random_cosine(1));
      end
    end
    release_channel();
  endtask

  task automatic test_backpressure();
    // Hold the result side for a long stretch while queries keep coming.
    hold_cycles = 400;
    for (int i = 0; i < 30; i++)
      query(18'($urandom_range(65536)), 18'($urandom_range(65536)),
            18'($urandom_range(131072) - 65536));
    release_channel();
  endtask

  initial begin
    sun_steps = 15;
    earth_steps = 15;
    azimuth_steps = 15;
    blue_weight = 0;
    foreach (grid_loaded[i]) grid_loaded[i] = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed_extremes();
    test_register_settings();

    // Coarse grids keep the set of corners that random queries touch small.
    send_idle_pct = 21; recv_idle_pct = 87;
    configure($urandom_range(1, 4), $urandom_range(1, 4), $urandom_range(1, 4),
              $urandom_range(65536));
    test_random_mix(250);

    send_idle_pct = 87; recv_idle_pct = 21;
    configure($urandom_range(4), $urandom_range(4), $urandom_range(4),
              $urandom_range(131071));
    test_random_mix(250);

    send_idle_pct = 0; recv_idle_pct = 0;
    configure(4, 4, 4, 65536);
    test_random_mix(350);
    test_backpressure();

    wait_idle();
    if (pending_factors.size() != 0) begin
      $error("%0d expected results never arrived", pending_factors.size());
      errors++;
    end
    $display("Covered %0d grid loads and %0d queries, %0d results checked,",
             loads_sent, queries_sent, results_seen);
    $display("across several interval and blend settings with both sides stalling.");
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
